>>> src/iphc_context_table_macros.svh
// Assertion macros used by the context table back end.
`ifndef IPHC_CONTEXT_TABLE_MACROS_SVH
`define IPHC_CONTEXT_TABLE_MACROS_SVH
// Check that an antecedent implies a consequent on the next clock edge.
`define IPHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
// Check that a condition holds at every clock edge outside reset.
`define IPHC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`endif

>>> src/iphc_pkg.sv
`default_nettype none
package iphc_pkg;
  localparam int unsigned TableEntriesDefault = 16;
  localparam int unsigned FullLen = 128;
  localparam logic [15:0] SolicitAt = 16'd5;

  localparam logic [1:0] ModePrefix = 2'd0;
  localparam logic [1:0] ModeId     = 2'd1;
  localparam logic [1:0] ModeUpdate = 2'd2;
  localparam logic [1:0] ModeTick   = 2'd3;

  localparam logic [1:0] StatusHit    = 2'd0;
  localparam logic [1:0] StatusMiss   = 2'd1;
  localparam logic [1:0] StatusReject = 2'd2;
  localparam logic [1:0] StatusDelete = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [3:0]  ctx_id;
    logic [7:0]  prefix_len;
    logic [15:0] lifetime;
    logic [7:0]  flags;
    logic [2:0]  device_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  entry_id;
    logic [63:0] entry_prefix_high;
    logic [63:0] entry_prefix_low;
    logic [7:0]  entry_prefix_len;
    logic [7:0]  entry_flags;
    logic [2:0]  entry_device;
    logic [15:0] entry_lifetime;
    logic [15:0] solicit_mask;
    logic [15:0] expired_mask;
  } rsp_t;

  // True when a and b agree over the first len bits; lengths above 128 count as 128.
  function automatic logic prefix_eq(logic [127:0] a, logic [127:0] b, logic [7:0] len);
    logic [127:0] m;
    m = '1;
    if (len < 8'd128) begin
      m = ~({128{1'b1}} >> len);
    end
    return ((a ^ b) & m) == '0;
  endfunction
endpackage
`default_nettype wire

>>> src/iphc_front.sv
`default_nettype none
// Front end: two-entry request queue between the input channel and the scan engine.
module iphc_front import iphc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid,
  output logic      in_ready,
  input  req_t      in_data,
  output logic      q_valid_o,
  input  wire logic q_pop_i,
  output req_t      q_data_o
);
  req_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready  = cnt_q != 2'd2;
  assign push      = in_valid && in_ready;
  assign pop       = q_pop_i && q_valid_o;
  assign q_valid_o = cnt_q != 2'd0;
  assign q_data_o  = mem_q[rd_q];

  // Pointer and fill count update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Payload storage.
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_data;
  end
endmodule
`default_nettype wire

>>> src/iphc_back.sv
`default_nettype none
`include "iphc_context_table_macros.svh"
// Back end: scans one slot per cycle, then decides, writes back and presents the result.
module iphc_back import iphc_pkg::*; #(
  parameter int unsigned TableEntries = TableEntriesDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  output logic      q_pop_o,
  input  req_t      q_data_i,
  output logic      out_valid,
  input  wire logic out_ready,
  output rsp_t      out_data
);
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam logic [CntW-1:0] Last = CntW'(TableEntries - 1);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [TableEntries-1:0] vld_q;
  logic [3:0]   id_q   [TableEntries];
  logic [127:0] pfx_q  [TableEntries];
  logic [7:0]   len_q  [TableEntries];
  logic [7:0]   flg_q  [TableEntries];
  logic [2:0]   dev_q  [TableEntries];
  logic [15:0]  life_q [TableEntries];

  logic [1:0]      st_q;
  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] idx;
  logic            hit_q, free_ok_q, dup_q;
  logic [IdxW-1:0] hit_s_q, free_s_q;
  logic [15:0]     sol_q, exp_q;
  rsp_t            rsp_q, rsp_d;
  req_t            r;
  logic [127:0]    addr;
  logic            match;
  logic [15:0]     dec;
  logic [15:0]     bit_s;

  assign r     = q_data_i;
  assign addr  = {r.addr_high, r.addr_low};
  assign idx   = cnt_q[IdxW-1:0];
  assign dec   = life_q[idx] - 16'd1;
  assign bit_s = (32'(cnt_q) < 32'd16) ? (16'd1 << cnt_q[IdxW-1:0]) : 16'd0;
  assign out_valid = st_q == StOut;
  assign out_data  = rsp_q;
  assign q_pop_o   = (st_q == StOut) && out_ready;

  // Per-slot match used by the lookups and updates.
  always_comb begin
    match = 1'b0;
    unique case (r.mode)
      ModePrefix: match = prefix_eq(addr, pfx_q[idx], len_q[idx]);
      ModeId, ModeUpdate: match = id_q[idx] == r.ctx_id;
      default: match = 1'b0;
    endcase
  end

  // Result of the request, formed from the scan outcome.
  always_comb begin
    rsp_d = '0;
    unique case (r.mode)
      ModePrefix, ModeId: begin
        if (hit_q) begin
          rsp_d.status = StatusHit;
          rsp_d.entry_id = id_q[hit_s_q];
          {rsp_d.entry_prefix_high, rsp_d.entry_prefix_low} = pfx_q[hit_s_q];
          rsp_d.entry_prefix_len = len_q[hit_s_q];
          rsp_d.entry_flags = flg_q[hit_s_q];
          rsp_d.entry_device = dev_q[hit_s_q];
          rsp_d.entry_lifetime = life_q[hit_s_q];
        end else begin
          rsp_d.status = StatusMiss;
        end
      end
      ModeUpdate: begin
        if (hit_q && dev_q[hit_s_q] == r.device_id) begin
          rsp_d.entry_id = id_q[hit_s_q];
          rsp_d.entry_device = dev_q[hit_s_q];
          if (r.lifetime == 16'd0) begin
            rsp_d.status = StatusDelete;
            {rsp_d.entry_prefix_high, rsp_d.entry_prefix_low} = pfx_q[hit_s_q];
            rsp_d.entry_prefix_len = len_q[hit_s_q];
            rsp_d.entry_flags = flg_q[hit_s_q];
            rsp_d.entry_lifetime = life_q[hit_s_q];
          end else begin
            rsp_d.status = StatusHit;
            {rsp_d.entry_prefix_high, rsp_d.entry_prefix_low} = addr;
            rsp_d.entry_prefix_len = r.prefix_len;
            rsp_d.entry_flags = r.flags;
            rsp_d.entry_lifetime = r.lifetime;
          end
        end else if (r.lifetime != 16'd0 && !dup_q && free_ok_q) begin
          rsp_d.status = StatusHit;
          rsp_d.entry_id = r.ctx_id;
          {rsp_d.entry_prefix_high, rsp_d.entry_prefix_low} = addr;
          rsp_d.entry_prefix_len = r.prefix_len;
          rsp_d.entry_flags = r.flags;
          rsp_d.entry_device = r.device_id;
          rsp_d.entry_lifetime = r.lifetime;
        end else begin
          rsp_d.status = StatusReject;
        end
      end
      default: begin
        rsp_d.status = StatusHit;
        rsp_d.solicit_mask = sol_q;
        rsp_d.expired_mask = exp_q;
      end
    endcase
  end

  // Sequencer and table state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      cnt_q <= '0;
      vld_q <= '0;
    end else begin
      unique case (st_q)
        StIdle: if (q_valid_i) begin
          st_q <= StScan;
          cnt_q <= '0;
        end
        StScan: begin
          if (r.mode == ModeTick && vld_q[idx] && dec == 16'd0) vld_q[idx] <= 1'b0;
          if (cnt_q == Last) st_q <= StDone;
          else cnt_q <= cnt_q + 1'b1;
        end
        StDone: begin
          st_q <= StOut;
          if (r.mode == ModeUpdate) begin
            if (hit_q && dev_q[hit_s_q] == r.device_id) begin
              if (r.lifetime == 16'd0) vld_q[hit_s_q] <= 1'b0;
            end else if (r.lifetime != 16'd0 && !dup_q && free_ok_q) begin
              vld_q[free_s_q] <= 1'b1;
            end
          end
        end
        StOut: if (out_ready) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  // Scan bookkeeping, slot payload and result register.
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: begin
        hit_q <= 1'b0;
        free_ok_q <= 1'b0;
        dup_q <= 1'b0;
        sol_q <= '0;
        exp_q <= '0;
      end
      StScan: begin
        if (vld_q[idx]) begin
          if (match && !hit_q) begin
            hit_q <= 1'b1;
            hit_s_q <= idx;
          end
          if (prefix_eq(addr, pfx_q[idx], r.prefix_len)) dup_q <= 1'b1;
          if (r.mode == ModeTick) begin
            life_q[idx] <= dec;
            if (dec == 16'd0) exp_q <= exp_q | bit_s;
            else if (dec == SolicitAt) sol_q <= sol_q | bit_s;
          end
        end else if (!free_ok_q) begin
          free_ok_q <= 1'b1;
          free_s_q <= idx;
        end
      end
      StDone: begin
        rsp_q <= rsp_d;
        if (r.mode == ModeUpdate) begin
          if (hit_q && dev_q[hit_s_q] == r.device_id) begin
            if (r.lifetime != 16'd0) begin
              pfx_q[hit_s_q] <= addr;
              len_q[hit_s_q] <= r.prefix_len;
              life_q[hit_s_q] <= r.lifetime;
              flg_q[hit_s_q] <= r.flags;
            end
          end else if (r.lifetime != 16'd0 && !dup_q && free_ok_q) begin
            id_q[free_s_q] <= r.ctx_id;
            pfx_q[free_s_q] <= addr;
            len_q[free_s_q] <= r.prefix_len;
            flg_q[free_s_q] <= r.flags;
            dev_q[free_s_q] <= r.device_id;
            life_q[free_s_q] <= r.lifetime;
          end
        end
      end
      default: ;
    endcase
  end

  `IPHC_ASSERT_ALWAYS(a_pop_out, clk_i, rst_ni, !q_pop_o || out_valid, "pop without result")
  `IPHC_ASSERT_NEXT(a_scan_end, clk_i, rst_ni, st_q == StScan && cnt_q == Last,
      st_q == StDone, "scan overran")
  `IPHC_ASSERT_NEXT(a_done_out, clk_i, rst_ni, st_q == StDone, out_valid, "no result")
  `IPHC_ASSERT_ALWAYS(a_work_has_req, clk_i, rst_ni, st_q == StIdle || q_valid_i,
      "working without request")
endmodule
`default_nettype wire

>>> src/iphc_context_table.sv
// Requests pass through the front queue, a scan of every slot, a decide and write-back step and the result register.
// The back end works on one request at a time, scanning one slot per cycle, and pops it only when its result is taken.
// A two-entry front queue takes requests while the back end scans or waits on output.
// Reset (rst_ni low, asynchronous) empties the queue and marks every slot invalid.
`default_nettype none
module iphc_context_table import iphc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid,
  output logic      in_ready,
  input  req_t      in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output rsp_t      out_data
);
  logic q_valid, q_pop;
  req_t q_data;

  iphc_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .in_data,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  iphc_back #(.TableEntries(TABLE_ENTRIES)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .out_valid, .out_ready, .out_data
  );
endmodule
`default_nettype wire
